### rtl/core/podi_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the odometry integrator.
package podi_pkg;

  localparam int CordicSteps = 16;

  localparam int StampW   = 48;
  localparam int VelW     = 24;
  localparam int GainW    = 17;
  localparam int PoseW    = 32;
  localparam int HeadW    = 19;
  localparam int CfgIdxW  = 2;

  localparam int DtW      = 32;   // saturated Q16.16 time step
  localparam int CoefW    = 18;   // Q.16 sine/cosine and zero-extended gains
  localparam int ProdW    = 60;   // product accumulator
  localparam int StepW    = 41;   // gain-scaled step, Q.16
  localparam int SumW     = 42;   // heading plus angular step
  localparam int RemW     = 19;
  localparam int CordW    = 34;   // Q2.30 with headroom
  localparam int CntW     = 6;
  localparam int StepIdxW = 5;

  localparam logic [CfgIdxW-1:0] CfgGainX    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGainY    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGainHead = 2'd2;

  localparam logic [GainW-1:0] GainOne = 17'd65536;

  localparam logic signed [RemW:0] PiQ16      = 20'sd205887;
  localparam logic signed [RemW:0] TurnQ16    = 20'sd411775;
  localparam logic signed [RemW:0] QuarterQ16 = 20'sd102944;
  localparam logic signed [CordW-1:0] CordicGainQ30 = 34'sd652032874;
  localparam logic signed [CordW-1:0] RoundQ14      = 34'sd8192;

  localparam logic [CntW-1:0] WrapBits = CntW'(SumW);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DT,
    ST_MUL,
    ST_POST,
    ST_WRAP,
    ST_WFIN,
    ST_CINIT,
    ST_CORDIC,
    ST_CFIN,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_VT_DT,
    OP_H_GAIN,
    OP_VF_DT,
    OP_X_GAIN,
    OP_VL_DT,
    OP_Y_GAIN,
    OP_DX_C,
    OP_DY_S,
    OP_DX_S,
    OP_DY_C
  } op_e;

  function automatic logic [31:0] atan_q30(input logic [StepIdxW-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd843314857;
      5'd1:  r = 32'd497837829;
      5'd2:  r = 32'd263043836;
      5'd3:  r = 32'd133525158;
      5'd4:  r = 32'd67021686;
      5'd5:  r = 32'd33543515;
      5'd6:  r = 32'd16775850;
      5'd7:  r = 32'd8388437;
      5'd8:  r = 32'd4194282;
      5'd9:  r = 32'd2097149;
      5'd10: r = 32'd1048575;
      5'd11: r = 32'd524287;
      5'd12: r = 32'd262143;
      5'd13: r = 32'd131071;
      5'd14: r = 32'd65535;
      5'd15: r = 32'd32767;
      5'd16: r = 32'd16383;
      5'd17: r = 32'd8191;
      5'd18: r = 32'd4095;
      5'd19: r = 32'd2047;
      5'd20: r = 32'd1023;
      5'd21: r = 32'd511;
      5'd22: r = 32'd255;
      5'd23: r = 32'd127;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // multiplier length in bits for each product, sign bit included
  function automatic logic [CntW-1:0] mul_len(input op_e op);
    logic [CntW-1:0] r;
    case (op)
      OP_VT_DT, OP_VF_DT, OP_VL_DT: r = CntW'(DtW);
      default:                      r = CntW'(CoefW);
    endcase
    return r;
  endfunction

endpackage

### rtl/core/podi_if.sv
// Valid/ready channel interfaces for update items and pose results.
interface podi_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic        [podi_pkg::StampW-1:0]  stamp;
  logic signed [podi_pkg::VelW-1:0]    vel_forward;
  logic signed [podi_pkg::VelW-1:0]    vel_lateral;
  logic signed [podi_pkg::VelW-1:0]    vel_turn;

  modport source (output valid, cmd, stamp, vel_forward, vel_lateral, vel_turn,
                  input ready);
  modport sink   (input valid, cmd, stamp, vel_forward, vel_lateral, vel_turn,
                  output ready);
endinterface

interface podi_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [podi_pkg::PoseW-1:0]  pose_x;
  logic signed [podi_pkg::PoseW-1:0]  pose_y;
  logic signed [podi_pkg::HeadW-1:0]  pose_heading;

  modport source (output valid, pose_x, pose_y, pose_heading, input ready);
  modport sink   (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

### rtl/core/planar_odometry_integrator.sv
// Flow: an update beat runs ST_DT, the multiplies, the heading wrap, the CORDIC and the
//   position multiplies before ST_OUT loads the output register; a pose-reset beat goes
//   straight to ST_OUT. One beat at a time: the input is ready only in ST_IDLE, and
//   ST_OUT waits while the output register holds an untaken result. The shared
//   bit-serial multiplier (one multiplier bit per cycle, ten products) and the 42-step
//   serial heading modulo bound the rate of update beats.
// Reset (rst_ni low, asynchronous): pose, heading and stored stamp cleared, all gains 1.0.
module planar_odometry_integrator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  podi_in_if.sink                       in_bus,
  podi_out_if.source                    out_bus,
  input  logic                          cfg_we_i,
  input  logic [podi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [podi_pkg::GainW-1:0]    cfg_data_i
);
  import podi_pkg::*;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [GainW-1:0] gain_x_q, gain_y_q, gain_h_q;

  // architectural accumulators
  logic signed [PoseW-1:0] pos_x_q, pos_x_d;
  logic signed [PoseW-1:0] pos_y_q, pos_y_d;
  logic signed [HeadW-1:0] head_q, head_d;
  logic [StampW-1:0]       last_stamp_q, last_stamp_d;

  // beat held for the duration of the work
  logic [StampW-1:0]       stamp_q, stamp_d;
  logic signed [VelW-1:0]  vf_q, vf_d, vl_q, vl_d, vt_q, vt_d;

  // shift-and-add multiplier: m shifts left, b shifts right one bit a cycle
  logic signed [ProdW-1:0] p_q, p_d;
  logic signed [ProdW-1:0] m_q, m_d;
  logic signed [DtW-1:0]   b_q, b_d;
  logic                    sub_q, sub_d;

  logic signed [DtW-1:0]   dt_q, dt_d;
  logic signed [StepW-1:0] hstep_q, hstep_d, dx_q, dx_d, dy_q, dy_d;

  // serial modulo by one full turn
  logic [SumW-1:0]         u_q, u_d;
  logic [RemW-1:0]         rem_q, rem_d;
  logic                    wneg_q, wneg_d;

  // CORDIC
  logic signed [CordW-1:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic                    cneg_q, cneg_d;
  logic signed [CoefW-1:0] cos_q, cos_d, sin_q, sin_d;

  // output register
  logic                    ovalid_q, ovalid_d;
  logic signed [PoseW-1:0] opx_q, opx_d, opy_q, opy_d;
  logic signed [HeadW-1:0] oh_q, oh_d;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic                    in_fire;
  logic                    mul_last;
  logic signed [ProdW-1:0] mul_term;
  logic signed [StampW:0]  diff;
  logic signed [DtW-1:0]   dt_sat;
  logic signed [ProdW-1:0] p_shr;       // product >>> 16, sign-extended
  logic signed [ProdW-1:0] p_step;      // 41-bit step field, sign-extended
  logic signed [SumW-1:0]  head_sum;
  logic [RemW:0]           r2;
  logic signed [RemW+1:0]  wr;
  logic signed [RemW+1:0]  wa;
  logic [StepIdxW-1:0]     cidx;
  logic signed [CordW-1:0] atan_v;
  logic signed [CordW-1:0] cx_sh, cy_sh;
  logic signed [CordW-1:0] cx_rnd, cy_rnd;
  logic signed [CoefW-1:0] c_r, s_r;
  logic signed [PoseW+12:0] pos_sum;
  logic signed [PoseW-1:0]  pos_sat;

  assign in_fire       = in_bus.valid && in_bus.ready;
  assign in_bus.ready  = (state_q == ST_IDLE);

  assign out_bus.valid        = ovalid_q;
  assign out_bus.pose_x       = opx_q;
  assign out_bus.pose_y       = opy_q;
  assign out_bus.pose_heading = oh_q;

  // two's complement multiplier: the top bit of b weighs negative
  assign mul_last = (cnt_q == mul_len(op_q) - CntW'(1));
  assign mul_term = (mul_last ^ sub_q) ? -m_q : m_q;

  assign diff   = $signed({1'b0, stamp_q}) - $signed({1'b0, last_stamp_q});
  always_comb begin
    if (diff[StampW:DtW-1] == '0 || diff[StampW:DtW-1] == '1) begin
      dt_sat = diff[DtW-1:0];
    end else if (diff[StampW]) begin
      dt_sat = {1'b1, {(DtW-1){1'b0}}};
    end else begin
      dt_sat = {1'b0, {(DtW-1){1'b1}}};
    end
  end

  assign p_shr    = {{16{p_q[ProdW-1]}}, p_q[ProdW-1:16]};
  assign p_step   = {{(ProdW-StepW){p_q[StepW+15]}}, p_q[StepW+15:16]};
  assign head_sum = {{(SumW-HeadW){head_q[HeadW-1]}}, head_q}
                  + {hstep_q[StepW-1], hstep_q};

  // restoring remainder step: shift in one dividend bit, subtract when it fits
  assign r2 = {rem_q, u_q[SumW-1]};

  // wrap into [-pi, pi]
  always_comb begin
    wr = wneg_q ? (TurnQ16 - 21'sd1 - $signed({2'b00, rem_q}))
                : $signed({2'b00, rem_q});
    if (wr > $signed({PiQ16[RemW], PiQ16})) begin
      wr = wr - $signed({TurnQ16[RemW], TurnQ16});
    end
  end

  // fold the heading into the CORDIC's convergence range
  always_comb begin
    wa = {{2{head_q[HeadW-1]}}, head_q};
    if (wa > $signed({QuarterQ16[RemW], QuarterQ16})) begin
      wa = wa - $signed({PiQ16[RemW], PiQ16});
    end else if (wa < -$signed({QuarterQ16[RemW], QuarterQ16})) begin
      wa = wa + $signed({PiQ16[RemW], PiQ16});
    end
  end

  assign cidx   = cnt_q[StepIdxW-1:0];
  assign atan_v = $signed({2'b00, atan_q30(cidx)});
  assign cx_sh  = cx_q >>> cidx;
  assign cy_sh  = cy_q >>> cidx;
  assign cx_rnd = cx_q + RoundQ14;
  assign cy_rnd = cy_q + RoundQ14;
  assign c_r    = cx_rnd[CoefW+13:14];
  assign s_r    = cy_rnd[CoefW+13:14];

  // position update with saturation to the signed 32-bit range
  always_comb begin
    pos_sum = {{13{pos_x_q[PoseW-1]}}, pos_x_q} + p_shr[PoseW+12:0];
    if (op_q == OP_DY_C) begin
      pos_sum = {{13{pos_y_q[PoseW-1]}}, pos_y_q} + p_shr[PoseW+12:0];
    end
    if (pos_sum[PoseW+12:PoseW-1] == '0 || pos_sum[PoseW+12:PoseW-1] == '1) begin
      pos_sat = pos_sum[PoseW-1:0];
    end else if (pos_sum[PoseW+12]) begin
      pos_sat = {1'b1, {(PoseW-1){1'b0}}};
    end else begin
      pos_sat = {1'b0, {(PoseW-1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    cnt_d        = cnt_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    head_d       = head_q;
    last_stamp_d = last_stamp_q;
    stamp_d      = stamp_q;
    vf_d         = vf_q;
    vl_d         = vl_q;
    vt_d         = vt_q;
    p_d          = p_q;
    m_d          = m_q;
    b_d          = b_q;
    sub_d        = sub_q;
    dt_d         = dt_q;
    hstep_d      = hstep_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    u_d          = u_q;
    rem_d        = rem_q;
    wneg_d       = wneg_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    cz_d         = cz_q;
    cneg_d       = cneg_q;
    cos_d        = cos_q;
    sin_d        = sin_q;
    opx_d        = opx_q;
    opy_d        = opy_q;
    oh_d         = oh_q;
    ovalid_d     = ovalid_q && !out_bus.ready;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_bus.cmd) begin
            pos_x_d = '0;
            pos_y_d = '0;
            head_d  = '0;
            state_d = ST_OUT;
          end else begin
            stamp_d = in_bus.stamp;
            vf_d    = in_bus.vel_forward;
            vl_d    = in_bus.vel_lateral;
            vt_d    = in_bus.vel_turn;
            state_d = ST_DT;
          end
        end
      end

      ST_DT: begin
        dt_d         = dt_sat;
        last_stamp_d = stamp_q;
        m_d          = {{(ProdW-VelW){vt_q[VelW-1]}}, vt_q};
        b_d          = dt_sat;
        p_d          = '0;
        sub_d        = 1'b0;
        cnt_d        = '0;
        op_d         = OP_VT_DT;
        state_d      = ST_MUL;
      end

      ST_MUL: begin
        if (b_q[0]) begin
          p_d = p_q + mul_term;
        end
        m_d   = m_q <<< 1;
        b_d   = b_q >>> 1;
        cnt_d = cnt_q + CntW'(1);
        if (mul_last) begin
          state_d = ST_POST;
        end
      end

      ST_POST: begin
        cnt_d   = '0;
        sub_d   = 1'b0;
        p_d     = '0;
        state_d = ST_MUL;
        case (op_q)
          OP_VT_DT: begin
            m_d  = p_shr;
            b_d  = {{(DtW-GainW){1'b0}}, gain_h_q};
            op_d = OP_H_GAIN;
          end
          OP_H_GAIN: begin
            hstep_d = p_step[StepW-1:0];
            m_d     = {{(ProdW-VelW){vf_q[VelW-1]}}, vf_q};
            b_d     = dt_q;
            op_d    = OP_VF_DT;
          end
          OP_VF_DT: begin
            m_d  = p_shr;
            b_d  = {{(DtW-GainW){1'b0}}, gain_x_q};
            op_d = OP_X_GAIN;
          end
          OP_X_GAIN: begin
            dx_d = p_step[StepW-1:0];
            m_d  = {{(ProdW-VelW){vl_q[VelW-1]}}, vl_q};
            b_d  = dt_q;
            op_d = OP_VL_DT;
          end
          OP_VL_DT: begin
            m_d  = p_shr;
            b_d  = {{(DtW-GainW){1'b0}}, gain_y_q};
            op_d = OP_Y_GAIN;
          end
          OP_Y_GAIN: begin
            dy_d    = p_step[StepW-1:0];
            wneg_d  = head_sum[SumW-1];
            u_d     = head_sum[SumW-1] ? ~head_sum : head_sum;
            rem_d   = '0;
            state_d = ST_WRAP;
          end
          OP_DX_C: begin
            // x delta: dx*cos - dy*sin, keep the running sum
            p_d   = p_q;
            m_d   = {{(ProdW-StepW){dy_q[StepW-1]}}, dy_q};
            b_d   = {{(DtW-CoefW){sin_q[CoefW-1]}}, sin_q};
            sub_d = 1'b1;
            op_d  = OP_DY_S;
          end
          OP_DY_S: begin
            pos_x_d = pos_sat;
            m_d     = {{(ProdW-StepW){dx_q[StepW-1]}}, dx_q};
            b_d     = {{(DtW-CoefW){sin_q[CoefW-1]}}, sin_q};
            op_d    = OP_DX_S;
          end
          OP_DX_S: begin
            // y delta: dx*sin + dy*cos
            p_d  = p_q;
            m_d  = {{(ProdW-StepW){dy_q[StepW-1]}}, dy_q};
            b_d  = {{(DtW-CoefW){cos_q[CoefW-1]}}, cos_q};
            op_d = OP_DY_C;
          end
          OP_DY_C: begin
            pos_y_d = pos_sat;
            state_d = ST_OUT;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_WRAP: begin
        if (r2 >= TurnQ16[RemW:0]) begin
          rem_d = RemW'(r2 - TurnQ16[RemW:0]);
        end else begin
          rem_d = r2[RemW-1:0];
        end
        u_d   = u_q << 1;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == WrapBits - CntW'(1)) begin
          state_d = ST_WFIN;
        end
      end

      ST_WFIN: begin
        head_d  = wr[HeadW-1:0];
        state_d = ST_CINIT;
      end

      ST_CINIT: begin
        cneg_d  = (wa != {{2{head_q[HeadW-1]}}, head_q});
        cx_d    = CordicGainQ30;
        cy_d    = '0;
        // folded angle times 2^14 needs well under 34 bits
        cz_d    = {wa[CordW-15:0], 14'd0};
        cnt_d   = '0;
        state_d = ST_CORDIC;
      end

      ST_CORDIC: begin
        if (!cz_q[CordW-1]) begin
          cx_d = cx_q - cy_sh;
          cy_d = cy_q + cx_sh;
          cz_d = cz_q - atan_v;
        end else begin
          cx_d = cx_q + cy_sh;
          cy_d = cy_q - cx_sh;
          cz_d = cz_q + atan_v;
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(CordicSteps - 1)) begin
          state_d = ST_CFIN;
        end
      end

      ST_CFIN: begin
        cos_d   = cneg_q ? -c_r : c_r;
        sin_d   = cneg_q ? -s_r : s_r;
        m_d     = {{(ProdW-StepW){dx_q[StepW-1]}}, dx_q};
        b_d     = cneg_q ? {{(DtW-CoefW){~c_r[CoefW-1]}}, -c_r}
                         : {{(DtW-CoefW){c_r[CoefW-1]}}, c_r};
        p_d     = '0;
        sub_d   = 1'b0;
        cnt_d   = '0;
        op_d    = OP_DX_C;
        state_d = ST_MUL;
      end

      ST_OUT: begin
        if (!ovalid_q || out_bus.ready) begin
          ovalid_d = 1'b1;
          opx_d    = pos_x_q;
          opy_d    = pos_y_q;
          oh_d     = head_q;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_VT_DT;
      cnt_q        <= '0;
      ovalid_q     <= 1'b0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      head_q       <= '0;
      last_stamp_q <= '0;
      gain_x_q     <= GainOne;
      gain_y_q     <= GainOne;
      gain_h_q     <= GainOne;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      cnt_q        <= cnt_d;
      ovalid_q     <= ovalid_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      head_q       <= head_d;
      last_stamp_q <= last_stamp_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgGainX:    gain_x_q <= cfg_data_i;
          CfgGainY:    gain_y_q <= cfg_data_i;
          CfgGainHead: gain_h_q <= cfg_data_i;
          default:     ;
        endcase
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    vf_q    <= vf_d;
    vl_q    <= vl_d;
    vt_q    <= vt_d;
    p_q     <= p_d;
    m_q     <= m_d;
    b_q     <= b_d;
    sub_q   <= sub_d;
    dt_q    <= dt_d;
    hstep_q <= hstep_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    u_q     <= u_d;
    rem_q   <= rem_d;
    wneg_q  <= wneg_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cz_q    <= cz_d;
    cneg_q  <= cneg_d;
    cos_q   <= cos_d;
    sin_q   <= sin_d;
    opx_q   <= opx_d;
    opy_q   <= opy_d;
    oh_q    <= oh_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= $signed(PiQ16[HeadW-1:0])) && (head_q >= -$signed(PiQ16[HeadW-1:0])))
    else $error("heading outside [-pi, pi]");

  a_pose_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_bus.cmd) |=> (state_q == ST_OUT && pos_x_q == '0 && head_q == '0))
    else $error("pose reset beat did not clear the pose");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (cnt_q < mul_len(op_q)))
    else $error("multiplier ran past its length");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == ST_OUT))
    else $error("result appeared without a finished beat");

endmodule
